// ===== hw/rtl/lkvc_pkg.sv =====
// lkvc_pkg: shared types and constants for the lru key-value cache
// no dependencies; imported by the top, lkvc_ctrl and lkvc_datapath, but not by lkvc_ram
package lkvc_pkg;

    localparam int LKVC_ENTRIES     = 16;
    localparam int LKVC_VALUE_WIDTH = 64;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 64;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] key;
        logic [DATA_W-1:0]       write_value;
    } t_in_item;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic cfg_write;
        logic load_in;
        logic lookup;
        logic commit;
    } t_dp_cmd;

endpackage

// ===== hw/rtl/lru_key_value_cache.sv =====
// lru_key_value_cache: fully associative key-value cache, lru replacement
// flow: a transaction is latched, then looked up (key match + ram read), then written back,
// which registers the result; a new transaction is accepted during that writeback
// a stalled result holds the writeback; no transaction is accepted while it waits
// reset: valid bits, ranks and count cleared, capacity set to 16; keys and
// values are not cleared
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES     = LKVC_ENTRIES,
    parameter int VALUE_WIDTH = LKVC_VALUE_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (dp_cmd)
    );

    lkvc_datapath #(
        .ENTRIES     (ENTRIES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in_data),
        .o_out      (o_out_data)
    );

    a_accept_then_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> dp_cmd.lookup)
        else $error("accepted transaction not followed by lookup");

    a_no_accept_in_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.lookup |-> (!o_in_ready && !dp_cmd.commit))
        else $error("accept or writeback during lookup");

    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.commit |-> (!o_out_valid || i_out_ready))
        else $error("writeback over an untaken result");

    a_commit_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.commit |=> o_out_valid)
        else $error("writeback without result");

endmodule

// ===== hw/rtl/lkvc_ram.sv =====
// lkvc_ram: generic one-write one-read ram with registered read data
// depends on nothing
module lkvc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/lkvc_ctrl.sv =====
// lkvc_ctrl: sequencer for the cache (accept, lookup, writeback/result)
// depends on lkvc_pkg
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_UPDATE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_finish;
    logic   in_ready;

    assign can_finish = !r_out_valid || i_out_ready;
    assign in_ready   = (r_state == ST_IDLE) || ((r_state == ST_UPDATE) && can_finish);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (can_finish) n_state = i_in_valid ? ST_LOOKUP : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result register frees when taken, refills on writeback
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) n_out_valid = 1'b0;
        if ((r_state == ST_UPDATE) && can_finish) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready      = in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_cfg_ready     = 1'b1;
    assign o_cmd.cfg_write = i_cfg_valid;
    assign o_cmd.load_in   = i_in_valid && in_ready;
    assign o_cmd.lookup    = (r_state == ST_LOOKUP);
    assign o_cmd.commit    = (r_state == ST_UPDATE) && can_finish;

endmodule

// ===== hw/rtl/lkvc_datapath.sv =====
// lkvc_datapath: entry keys, ages, valid bits, parallel match, value ram
// depends on lkvc_pkg and lkvc_ram
module lkvc_datapath
    import lkvc_pkg::*;
#(
    parameter int ENTRIES     = LKVC_ENTRIES,
    parameter int VALUE_WIDTH = LKVC_VALUE_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  t_in_item         i_in,
    output t_out_item        o_out
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // latched transaction
    logic                   r_cmd;
    logic [KEY_W-1:0]       r_key;
    logic [VALUE_WIDTH-1:0] r_wval;

    // entry state
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [KEY_W-1:0]   r_entry_key [ENTRIES];
    logic [IDX_W-1:0]   r_age [ENTRIES];
    logic [IDX_W-1:0]   n_age [ENTRIES];
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CAP_W-1:0]   r_capacity;

    // lookup results
    logic             r_hit;
    logic             r_fill;
    logic             r_evict;
    logic [IDX_W-1:0] r_match_idx;
    logic [IDX_W-1:0] r_match_age;
    logic [IDX_W-1:0] r_slot_idx;
    logic [IDX_W-1:0] r_victim_idx;

    t_out_item r_out;

    logic [ENTRIES-1:0]     match_vec;
    logic [ENTRIES-1:0]     victim_vec;
    logic [ENTRIES-1:0]     free_vec;
    logic                   any_match;
    logic [IDX_W-1:0]       match_idx;
    logic [IDX_W-1:0]       victim_idx;
    logic [IDX_W-1:0]       slot_idx;
    logic [IDX_W-1:0]       oldest_age;
    logic [CMP_W-1:0]       cap_eff;
    logic                   need_evict;
    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    logic [VALUE_WIDTH-1:0] ram_rd_data;

    // capacity clamped to 1..ENTRIES
    always_comb begin
        cap_eff = CMP_W'(r_capacity);
        if (cap_eff == '0) cap_eff = CMP_W'(1);
        if (cap_eff > CMP_W'(ENTRIES)) cap_eff = CMP_W'(ENTRIES);
    end

    assign need_evict = (CMP_W'(r_count) >= cap_eff);
    assign oldest_age = IDX_W'(r_count - 1'b1);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i]  = r_valid[i] && (r_entry_key[i] == r_key);
            victim_vec[i] = r_valid[i] && need_evict && (r_age[i] == oldest_age);
        end
        free_vec = ~r_valid | victim_vec;
    end

    // lowest set index of each vector
    always_comb begin
        match_idx  = '0;
        victim_idx = '0;
        slot_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match_vec[i])  match_idx  = IDX_W'(i);
            if (victim_vec[i]) victim_idx = IDX_W'(i);
            if (free_vec[i])   slot_idx   = IDX_W'(i);
        end
    end

    assign any_match = |match_vec;

    // writeback of recency ranks, valid bits and count
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < ENTRIES; i++) begin
            n_age[i] = r_age[i];
        end
        if (i_cmd.commit) begin
            if (r_hit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == r_match_idx) begin
                        n_age[i] = '0;
                    end else if (r_valid[i] && (r_age[i] < r_match_age)) begin
                        n_age[i] = r_age[i] + 1'b1;
                    end
                end
            end else if (r_fill) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == r_slot_idx) begin
                        n_valid[i] = 1'b1;
                        n_age[i]   = '0;
                    end else if (r_evict && (IDX_W'(i) == r_victim_idx)) begin
                        n_valid[i] = 1'b0;
                        n_age[i]   = '0;
                    end else if (r_valid[i]) begin
                        n_age[i] = r_age[i] + 1'b1;
                    end
                end
                if (!r_evict) n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_count    <= '0;
            r_capacity <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= n_age[i];
            end
            if (i_cmd.cfg_write) r_capacity <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd  <= i_in.command;
            r_key  <= i_in.key;
            r_wval <= i_in.write_value[VALUE_WIDTH-1:0];
        end
        if (i_cmd.lookup) begin
            r_hit        <= any_match;
            r_fill       <= (r_cmd == CMD_PUT) && !any_match;
            r_evict      <= (r_cmd == CMD_PUT) && !any_match && need_evict;
            r_match_idx  <= match_idx;
            r_match_age  <= r_age[match_idx];
            r_slot_idx   <= slot_idx;
            r_victim_idx <= victim_idx;
        end
        if (i_cmd.commit && r_fill) begin
            r_entry_key[r_slot_idx] <= r_key;
        end
        if (i_cmd.commit) begin
            r_out.hit        <= r_hit;
            r_out.read_value <= (r_hit && (r_cmd == CMD_GET)) ? DATA_W'(ram_rd_data) : '0;
        end
    end

    assign ram_wr_en   = i_cmd.commit && (r_cmd == CMD_PUT);
    assign ram_wr_addr = r_hit ? r_match_idx : r_slot_idx;

    lkvc_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (r_wval),
        .i_rd_en   (i_cmd.lookup),
        .i_rd_addr (match_idx),
        .o_rd_data (ram_rd_data)
    );

    assign o_out = r_out;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for lru_key_value_cache, directed table then random phases
// get/put checked against an lru predictor here or fixed row values; needs lkvc_pkg and the rtl
module tb;
    import lkvc_pkg::*;

    localparam int N_SLOTS   = LKVC_ENTRIES;
    localparam int N_PHASES  = 10;
    localparam int PHASE_LEN = 75;
    localparam int POOL_SIZE = 20;
    localparam int CALM_PHASE  = 4;
    localparam int HOLD_PHASE  = 2;
    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_NEG = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
    localparam logic [CAP_W-1:0] PHASE_CAPS [N_PHASES] =
        '{5'd16, 5'd0, 5'd1, 5'd31, 5'd3, 5'd8, 5'd17, 5'd2, 5'd15, 5'd5};

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic              cmd;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        logic              typed;
        logic              exp_hit;
        logic [DATA_W-1:0] exp_value;
    } t_dir_row;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_item         in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b1;
    t_out_item        out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data  = '0;

    bit calm = 1'b0;
    int errors = 0;
    int n_sent = 0;
    int n_replies = 0;
    int n_hits = 0;
    int n_cfg = 0;

    // predictor state
    logic              slot_valid [N_SLOTS];
    logic [KEY_W-1:0]  slot_key   [N_SLOTS];
    logic [DATA_W-1:0] slot_value [N_SLOTS];
    int unsigned       slot_rank  [N_SLOTS];
    int unsigned       slot_count;
    logic [CAP_W-1:0]  capacity;

    t_out_item        lookup_replies[$];
    t_dir_row         dir_rows[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    always #4 clk = ~clk;

    lru_key_value_cache dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always @(negedge clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= 7);
    end

    // slot s becomes most recent; valid slots younger than limit age by one
    function automatic void make_recent(int s, int unsigned limit);
        for (int i = 0; i < N_SLOTS; i++) begin
            if (i != s && slot_valid[i] && slot_rank[i] < limit) slot_rank[i]++;
        end
        slot_rank[s] = 0;
    endfunction

    function automatic t_out_item lru_access(t_in_item it);
        t_out_item   r;
        int          hit_slot;
        int          oldest;
        int unsigned cap_eff;
        r        = '0;
        hit_slot = -1;
        oldest   = -1;
        cap_eff  = (capacity == 0) ? 1 : (capacity > N_SLOTS) ? N_SLOTS : capacity;
        for (int i = 0; i < N_SLOTS; i++) begin
            if (hit_slot < 0 && slot_valid[i] && slot_key[i] == it.key) hit_slot = i;
        end
        if (hit_slot >= 0) begin
            r.hit = 1'b1;
            if (it.command == CMD_GET) r.read_value = slot_value[hit_slot];
            else slot_value[hit_slot] = it.write_value;
            make_recent(hit_slot, slot_rank[hit_slot]);
        end else if (it.command == CMD_PUT) begin
            // at or over capacity: drop exactly one least recent entry
            if (slot_count >= cap_eff && slot_count > 0) begin
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (slot_valid[i] && (oldest < 0 || slot_rank[i] > slot_rank[oldest]))
                        oldest = i;
                end
                if (oldest >= 0) begin
                    slot_valid[oldest] = 1'b0;
                    slot_rank[oldest]  = 0;
                    slot_count--;
                end
            end
            for (int i = 0; i < N_SLOTS; i++) begin
                if (!slot_valid[i]) begin
                    slot_valid[i] = 1'b1;
                    slot_key[i]   = it.key;
                    slot_value[i] = it.write_value;
                    make_recent(i, N_SLOTS + 1);
                    slot_count++;
                    break;
                end
            end
        end
        return r;
    endfunction

    function automatic t_dir_row op_row(logic cmd, logic [KEY_W-1:0] key,
                                        logic [DATA_W-1:0] value);
        t_dir_row r;
        r       = '0;
        r.kind  = ROW_ITEM;
        r.cmd   = cmd;
        r.key   = key;
        r.value = value;
        return r;
    endfunction

    function automatic t_dir_row fixed_row(logic cmd, logic [KEY_W-1:0] key,
                                           logic [DATA_W-1:0] value, logic hit,
                                           logic [DATA_W-1:0] read_value);
        t_dir_row r;
        r           = op_row(cmd, key, value);
        r.typed     = 1'b1;
        r.exp_hit   = hit;
        r.exp_value = read_value;
        return r;
    endfunction

    function automatic t_dir_row cap_row(logic [CAP_W-1:0] cap);
        t_dir_row r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.value = DATA_W'(cap);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            n_replies++;
            if (lookup_replies.size() == 0) begin
                report_mismatch("result transaction with nothing outstanding");
            end else begin
                want = lookup_replies.pop_front();
                if (want.hit) n_hits++;
                if (out_data.hit !== want.hit)
                    report_mismatch($sformatf("hit %b, expected %b", out_data.hit, want.hit));
                if (out_data.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, expected %h",
                                              out_data.read_value, want.read_value));
            end
        end
    end

    task automatic send_item(t_in_item it, logic typed, t_out_item typed_exp);
        t_out_item pred;
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 7) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        pred = lru_access(it);
        lookup_replies.push_back(typed ? typed_exp : pred);
        n_sent++;
    endtask

    task automatic drain_replies();
        @(negedge clk);
        in_valid <= 1'b0;
        while (lookup_replies.size() != 0) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain_replies();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        capacity = cap;
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        t_in_item  it;
        t_out_item fixed_exp;
        for (int i = 0; i < N_SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_rank[i]  = 0;
        end
        slot_count = 0;
        capacity   = CAP_RESET;
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = KEY_NEG;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        // directed: empty cache, key and value extremes, put on a present key, get ignoring
        // write data, then capacity lowered below the count, zero and above the entry count
        dir_rows.push_back(fixed_row(CMD_GET, '0, '0, 1'b0, '0));
        dir_rows.push_back(fixed_row(CMD_PUT, KEY_MIN, ALL_ONES, 1'b0, '0));
        dir_rows.push_back(fixed_row(CMD_GET, KEY_MIN, '0, 1'b1, ALL_ONES));
        dir_rows.push_back(fixed_row(CMD_PUT, KEY_MAX, '0, 1'b0, '0));
        dir_rows.push_back(fixed_row(CMD_PUT, KEY_MAX, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, '0));
        dir_rows.push_back(fixed_row(CMD_GET, KEY_MAX, ALL_ONES, 1'b1, 64'hA5A5_A5A5_A5A5_A5A5));
        dir_rows.push_back(fixed_row(CMD_GET, KEY_NEG, 64'h1234, 1'b0, '0));
        dir_rows.push_back(fixed_row(CMD_PUT, KEY_NEG, 64'd1, 1'b0, '0));
        dir_rows.push_back(op_row(CMD_PUT, '0, 64'h5A5A_5A5A_5A5A_5A5A));
        dir_rows.push_back(op_row(CMD_GET, KEY_MIN, '0));
        dir_rows.push_back(cap_row(5'd2));
        dir_rows.push_back(op_row(CMD_PUT, 32'd5, 64'd5));
        dir_rows.push_back(op_row(CMD_GET, KEY_MAX, '0));
        dir_rows.push_back(op_row(CMD_PUT, 32'd6, 64'd6));
        dir_rows.push_back(op_row(CMD_GET, 32'd5, '0));
        dir_rows.push_back(op_row(CMD_PUT, 32'd7, 64'd7));
        dir_rows.push_back(cap_row(5'd0));
        dir_rows.push_back(op_row(CMD_PUT, 32'd8, 64'd8));
        dir_rows.push_back(op_row(CMD_PUT, 32'd9, 64'd9));
        dir_rows.push_back(op_row(CMD_GET, 32'd9, '0));
        dir_rows.push_back(op_row(CMD_GET, 32'd8, '0));
        dir_rows.push_back(cap_row(5'd31));
        dir_rows.push_back(op_row(CMD_PUT, 32'd10, 64'd10));
        dir_rows.push_back(op_row(CMD_PUT, 32'd11, 64'd11));
        dir_rows.push_back(op_row(CMD_GET, 32'd9, '0));
        dir_rows.push_back(cap_row(5'd16));
        dir_rows.push_back(op_row(CMD_GET, 32'd10, '0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_capacity(dir_rows[r].value[CAP_W-1:0]);
            end else begin
                it.command        = dir_rows[r].cmd;
                it.key            = dir_rows[r].key;
                it.write_value    = dir_rows[r].value;
                fixed_exp.hit        = dir_rows[r].exp_hit;
                fixed_exp.read_value = dir_rows[r].exp_value;
                send_item(it, dir_rows[r].typed, fixed_exp);
            end
        end

        // random phases: keys mostly from a small pool so hits and evictions both happen
        fixed_exp = '0;
        for (int p = 0; p < N_PHASES; p++) begin
            write_capacity(PHASE_CAPS[p]);
            calm = (p == CALM_PHASE);
            for (int j = 0; j < PHASE_LEN; j++) begin
                if (p == HOLD_PHASE && j == PHASE_LEN / 2) drain_replies();
                it.command     = ($urandom_range(0, 99) < 55) ? CMD_PUT : CMD_GET;
                it.key         = ($urandom_range(0, 9) == 0) ? $urandom
                                 : key_pool[$urandom_range(0, POOL_SIZE - 1)];
                it.write_value = {$urandom, $urandom};
                send_item(it, 1'b0, fixed_exp);
            end
        end
        calm = 1'b0;

        drain_replies();
        repeat (20) @(posedge clk);

        $display("covered %0d get/put transactions, %0d results, %0d hits", n_sent, n_replies,
                 n_hits);
        $display("capacity written %0d times, including 0, 1, 16, 31 and below the count", n_cfg);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for a handshake");
        $display("status: fail");
        $finish;
    end

endmodule
